### rtl/assert_macros.svh
// Assertion macros used by the checker file of the note trigger unit.
// No dependencies; each macro expects clk in scope, and the masked ones also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PNT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, masked during reset.
`define PNT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that is also checked across reset.
`define PNT_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/pnt_pkg.sv
// Shared types and constants of the piezo note trigger unit.
// No dependencies.
package pnt_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TIME_BITS   = 32;
  localparam int VAL_BITS    = 7;
  localparam int DIV_CNT_W   = $clog2(SAMPLE_BITS);
  localparam int ADDR_BITS   = 5;

  localparam logic [TIME_BITS-1:0]   WINDOW_US   = TIME_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] THR_RESET   = SAMPLE_BITS'(80);
  localparam logic [SAMPLE_BITS-1:0] FLOOR_RESET = SAMPLE_BITS'(3);
  localparam logic [TIME_BITS-1:0]   HOLD_RESET  = TIME_BITS'(10000);
  localparam logic [SAMPLE_BITS-1:0] DIV_RESET   = SAMPLE_BITS'(8);
  localparam logic [VAL_BITS-1:0]    HI_RESET    = VAL_BITS'(127);

  typedef enum logic [2:0] {
    REG_VMODE   = 3'd0,
    REG_THRESH  = 3'd1,
    REG_FLOOR   = 3'd2,
    REG_HOLDOFF = 3'd3,
    REG_DIVIDER = 3'd4,
    REG_OUT_LO  = 3'd5,
    REG_OUT_HI  = 3'd6,
    REG_NOTE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                   velocity_mode;
    logic [SAMPLE_BITS-1:0] threshold;
    logic [SAMPLE_BITS-1:0] floor_level;
    logic [TIME_BITS-1:0]   holdoff_us;
    logic [SAMPLE_BITS-1:0] scale_divider;
    logic [VAL_BITS-1:0]    out_lo;
    logic [VAL_BITS-1:0]    out_hi;
    logic [VAL_BITS-1:0]    note_number;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIV    = 2'd1,
    ST_COMMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic load;    // capture request, start divider
    logic step;    // one divider iteration
    logic commit;  // update state and output register
  } cmd_t;

endpackage

### rtl/pnt_cfg_regs.sv
// Configuration register file with APB-style access.
// Depends on pnt_pkg.
module pnt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pnt_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output pnt_pkg::cfg_t                 cfg
);
  import pnt_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_BITS-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_VMODE:   cfg_nxt.velocity_mode = cfg_pwdata[0];
        REG_THRESH:  cfg_nxt.threshold     = cfg_pwdata[SAMPLE_BITS-1:0];
        REG_FLOOR:   cfg_nxt.floor_level   = cfg_pwdata[SAMPLE_BITS-1:0];
        REG_HOLDOFF: cfg_nxt.holdoff_us    = cfg_pwdata[TIME_BITS-1:0];
        REG_DIVIDER: cfg_nxt.scale_divider = cfg_pwdata[SAMPLE_BITS-1:0];
        REG_OUT_LO:  cfg_nxt.out_lo        = cfg_pwdata[VAL_BITS-1:0];
        REG_OUT_HI:  cfg_nxt.out_hi        = cfg_pwdata[VAL_BITS-1:0];
        REG_NOTE:    cfg_nxt.note_number   = cfg_pwdata[VAL_BITS-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VMODE:   cfg_prdata = 32'(cfg_r.velocity_mode);
      REG_THRESH:  cfg_prdata = 32'(cfg_r.threshold);
      REG_FLOOR:   cfg_prdata = 32'(cfg_r.floor_level);
      REG_HOLDOFF: cfg_prdata = 32'(cfg_r.holdoff_us);
      REG_DIVIDER: cfg_prdata = 32'(cfg_r.scale_divider);
      REG_OUT_LO:  cfg_prdata = 32'(cfg_r.out_lo);
      REG_OUT_HI:  cfg_prdata = 32'(cfg_r.out_hi);
      REG_NOTE:    cfg_prdata = 32'(cfg_r.note_number);
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.velocity_mode <= 1'b0;
      cfg_r.threshold     <= THR_RESET;
      cfg_r.floor_level   <= FLOOR_RESET;
      cfg_r.holdoff_us    <= HOLD_RESET;
      cfg_r.scale_divider <= DIV_RESET;
      cfg_r.out_lo        <= '0;
      cfg_r.out_hi        <= HI_RESET;
      cfg_r.note_number   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/pnt_ctrl.sv
// Controller: sequences capture, divider iterations and commit, and owns
// the output valid flag. Depends on pnt_pkg.
module pnt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output pnt_pkg::cmd_t cmd
);
  import pnt_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 oval_r, oval_nxt;
  logic                 out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = oval_r;
  assign out_free  = !oval_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    oval_nxt   = oval_r & out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SAMPLE_BITS-1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // wait until the output register is empty or being drained
        if (out_free) begin
          cmd.commit = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

### rtl/pnt_datapath.sv
// Datapath: sample capture, restoring divider, trigger state and the
// output register. Depends on pnt_pkg.
module pnt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pnt_pkg::cmd_t                   cmd,
  input  pnt_pkg::cfg_t                   cfg,
  input  logic [pnt_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [pnt_pkg::TIME_BITS-1:0]   in_now_us,
  output logic                            out_event_valid,
  output logic [pnt_pkg::VAL_BITS-1:0]    out_event_value,
  output logic [pnt_pkg::VAL_BITS-1:0]    out_event_note,
  output logic signed [7:0]               out_aftertouch
);
  import pnt_pkg::*;

  logic [SAMPLE_BITS-1:0] smp_r;
  logic [TIME_BITS-1:0]   now_r, elap_r;
  logic [SAMPLE_BITS-1:0] rem_r, quo_r;
  logic [SAMPLE_BITS-1:0] divisor;
  logic [SAMPLE_BITS:0]   trial;
  logic                   qbit;
  logic [SAMPLE_BITS-1:0] dividend;

  logic                   hold_r, hold_nxt;
  logic                   note_r, note_nxt;
  logic                   spike_r, spike_nxt;
  logic [SAMPLE_BITS-1:0] wh_r, wh_nxt, wl_r, wl_nxt;
  logic [TIME_BITS-1:0]   mark_r, mark_nxt;
  logic [7:0]             press_r, press_nxt;

  logic                   ev_valid;
  logic [VAL_BITS-1:0]    ev_value;
  logic [VAL_BITS-1:0]    scaled;
  logic [SAMPLE_BITS:0]   low_plus_thr;

  logic                   ov_r;
  logic [VAL_BITS-1:0]    oval_r, onote_r;
  logic [7:0]             oat_r;

  // zero divider behaves as one
  assign divisor = (cfg.scale_divider == '0) ? SAMPLE_BITS'(1) : cfg.scale_divider;
  assign trial   = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign qbit    = (trial >= {1'b0, divisor});

  // while listening the divider works on the updated window peak
  assign dividend = (note_r || in_sample > wh_r) ? in_sample : wh_r;

  // raise to out_lo, or else lower to out_hi (if they cross, out_lo wins below out_lo, else out_hi)
  always_comb begin
    if (quo_r < SAMPLE_BITS'(cfg.out_lo)) begin
      scaled = cfg.out_lo;
    end else if (quo_r > SAMPLE_BITS'(cfg.out_hi)) begin
      scaled = cfg.out_hi;
    end else begin
      scaled = quo_r[VAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= in_sample;
      now_r <= in_now_us;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (cmd.step) begin
      rem_r <= qbit ? SAMPLE_BITS'(trial - {1'b0, divisor}) : trial[SAMPLE_BITS-1:0];
      quo_r <= {quo_r[SAMPLE_BITS-2:0], qbit};
    end
    // mark_r only moves on commit, so this is settled long before use
    elap_r <= now_r - mark_r;
  end

  always_comb begin
    hold_nxt     = hold_r;
    note_nxt     = note_r;
    spike_nxt    = spike_r;
    wh_nxt       = wh_r;
    wl_nxt       = wl_r;
    mark_nxt     = mark_r;
    press_nxt    = press_r;
    ev_valid     = 1'b0;
    ev_value     = '0;
    low_plus_thr = '0;
    if (hold_r) begin
      if (elap_r > cfg.holdoff_us && smp_r <= cfg.floor_level) begin
        hold_nxt = 1'b0;
        mark_nxt = now_r;
      end
    end else if (cfg.velocity_mode) begin
      if (note_r) begin
        if (smp_r < cfg.threshold) begin
          ev_valid  = 1'b1;
          ev_value  = cfg.out_lo;
          press_nxt = '0;
          note_nxt  = 1'b0;
          hold_nxt  = 1'b1;
          wh_nxt    = '0;
          wl_nxt    = cfg.threshold;
          mark_nxt  = now_r;
        end else begin
          press_nxt = {1'b0, scaled};
        end
      end else begin
        press_nxt = 8'hFF;
        if (smp_r > wh_r) begin
          wh_nxt = smp_r;
        end else if (smp_r < wl_r && !spike_r) begin
          wl_nxt = smp_r;
        end
        low_plus_thr = {1'b0, wl_nxt} + {1'b0, cfg.threshold};
        if (elap_r >= WINDOW_US) begin
          if (spike_r) begin
            ev_valid  = 1'b1;
            ev_value  = scaled;
            note_nxt  = 1'b1;
            spike_nxt = 1'b0;
          end else if ({1'b0, wh_nxt} > low_plus_thr) begin
            spike_nxt = 1'b1;
          end else begin
            wh_nxt = '0;
            wl_nxt = smp_r;
          end
          mark_nxt = now_r;
        end
      end
    end else begin
      if (!note_r && smp_r > cfg.threshold) begin
        ev_valid = 1'b1;
        ev_value = cfg.out_hi;
        note_nxt = 1'b1;
      end else if (note_r && smp_r <= cfg.threshold) begin
        ev_valid = 1'b1;
        ev_value = cfg.out_lo;
        note_nxt = 1'b0;
        hold_nxt = 1'b1;
        mark_nxt = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      note_r  <= 1'b0;
      spike_r <= 1'b0;
      wh_r    <= '0;
      wl_r    <= THR_RESET;
      mark_r  <= '0;
      press_r <= '0;
    end else if (cmd.commit) begin
      hold_r  <= hold_nxt;
      note_r  <= note_nxt;
      spike_r <= spike_nxt;
      wh_r    <= wh_nxt;
      wl_r    <= wl_nxt;
      mark_r  <= mark_nxt;
      press_r <= press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ov_r    <= ev_valid;
      oval_r  <= ev_value;
      onote_r <= cfg.note_number;
      oat_r   <= press_nxt;
    end
  end

  assign out_event_valid = ov_r;
  assign out_event_value = oval_r;
  assign out_event_note  = onote_r;
  assign out_aftertouch  = $signed(oat_r);

endmodule

### rtl/piezo_note_trigger_unit.sv
// Piezo note trigger unit: sample-to-note-event converter, top level.
// Depends on pnt_pkg, pnt_cfg_regs, pnt_ctrl, pnt_datapath.
//
// Input channel: one request carries a sensor sample and its microsecond
// timestamp. Output channel: exactly one result per request with event
// valid/value, note number and aftertouch (-1 while listening).
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Each request is captured on acceptance, then the restoring divider runs
// (one quotient bit per step), then the commit step writes the output
// register. in_stall is high from acceptance until commit, so the unit
// takes no new request until the current one has committed.
// The result sits in an output register; the next request is accepted and
// divided while it waits. If the receiver still stalls at commit time,
// the unit holds in the commit step until the register drains.
// Reset (synchronous, active low) restores register defaults, clears the
// note, spike and holdoff state and empties the output register.
// Registers are written through the APB-style port at byte address 4*i; the user must
// write them only while the unit is idle, which the block itself does not enforce.
module piezo_note_trigger_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pnt_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [pnt_pkg::TIME_BITS-1:0]   in_now_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_event_valid,
  output logic [pnt_pkg::VAL_BITS-1:0]    out_event_value,
  output logic [pnt_pkg::VAL_BITS-1:0]    out_event_note,
  output logic signed [7:0]               out_aftertouch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pnt_pkg::ADDR_BITS-1:0]   cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import pnt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  pnt_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pnt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_sample       (in_sample),
    .in_now_us       (in_now_us),
    .out_event_valid (out_event_valid),
    .out_event_value (out_event_value),
    .out_event_note  (out_event_note),
    .out_aftertouch  (out_aftertouch)
  );

endmodule

### rtl/pnt_checker.sv
// Port-level checker for the piezo note trigger unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pnt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_event_valid,
  input logic [6:0]        out_event_value
);

  // one request in flight: acceptance closes the input side
  `PNT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a pending result is not dropped while stalled
  `PNT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // without an event the value reads zero
  `PNT_ASSERT_NOW(a_no_event_value, out_valid && !out_event_valid, out_event_value == 7'd0)

  // reset leaves both sides empty and open
  `PNT_ASSERT_NEXT_ANY(a_reset_idle, !rst_n, !in_stall && !out_valid)

endmodule

bind piezo_note_trigger_unit pnt_checker u_pnt_checker (.*);

### verif/piezo_note_trigger_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for piezo_note_trigger_unit: directed and random sample streams.
// Depends on pnt_pkg and the piezo_note_trigger_unit RTL.
module piezo_note_trigger_unit_tb;
  import pnt_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SESSIONS      = 10;
  localparam int SESSION_ITEMS = 190;

  typedef struct packed {
    logic                ev_valid;
    logic [VAL_BITS-1:0] ev_value;
    logic [VAL_BITS-1:0] ev_note;
    logic [7:0]          touch;
  } note_event_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic [TIME_BITS-1:0]   in_now_us = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_event_valid;
  logic [VAL_BITS-1:0]    out_event_value;
  logic [VAL_BITS-1:0]    out_event_note;
  logic signed [7:0]      out_aftertouch;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0]   cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // shadow of the register file and the trigger state
  cfg_t                   trig_cfg;
  logic                   holdoff_on = 1'b0;
  logic                   note_on = 1'b0;
  logic                   spike_on = 1'b0;
  logic [SAMPLE_BITS-1:0] win_high = '0;
  logic [SAMPLE_BITS-1:0] win_low = THR_RESET;
  logic [TIME_BITS-1:0]   mark_us = '0;
  logic [7:0]             pressure = '0;

  note_event_t          expected_events[$];
  logic [TIME_BITS-1:0] stamp_us = '0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int settings_used = 0;

  piezo_note_trigger_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_now_us(in_now_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_valid(out_event_valid),
    .out_event_value(out_event_value),
    .out_event_note(out_event_note),
    .out_aftertouch(out_aftertouch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // divide, then raise to out_lo or else cut to out_hi
  function automatic logic [VAL_BITS-1:0] scale_to_range(input logic [SAMPLE_BITS-1:0] level);
    logic [SAMPLE_BITS-1:0] divisor;
    logic [SAMPLE_BITS-1:0] quot;
    divisor = (trig_cfg.scale_divider == '0) ? SAMPLE_BITS'(1) : trig_cfg.scale_divider;
    quot = level / divisor;
    if (quot < SAMPLE_BITS'(trig_cfg.out_lo)) return trig_cfg.out_lo;
    if (quot > SAMPLE_BITS'(trig_cfg.out_hi)) return trig_cfg.out_hi;
    return quot[VAL_BITS-1:0];
  endfunction

  function automatic note_event_t next_note_event(input logic [SAMPLE_BITS-1:0] s,
                                                  input logic [TIME_BITS-1:0] now);
    note_event_t ev;
    logic [TIME_BITS-1:0] elapsed;
    int span;
    ev = '0;
    elapsed = now - mark_us;
    if (holdoff_on) begin
      if (elapsed > trig_cfg.holdoff_us && s <= trig_cfg.floor_level) begin
        holdoff_on = 1'b0;
        mark_us = now;
      end
    end else if (trig_cfg.velocity_mode) begin
      if (note_on) begin
        if (s < trig_cfg.threshold) begin
          ev.ev_valid = 1'b1;
          ev.ev_value = trig_cfg.out_lo;
          pressure = '0;
          note_on = 1'b0;
          holdoff_on = 1'b1;
          win_high = '0;
          win_low = trig_cfg.threshold;
          mark_us = now;
        end else begin
          pressure = {1'b0, scale_to_range(s)};
        end
      end else begin
        pressure = 8'hFF;
        if (s > win_high) win_high = s;
        else if (s < win_low && !spike_on) win_low = s;
        if (elapsed >= WINDOW_US) begin
          span = int'(win_high) - int'(win_low);
          if (spike_on) begin
            ev.ev_valid = 1'b1;
            ev.ev_value = scale_to_range(win_high);
            note_on = 1'b1;
            spike_on = 1'b0;
          end else if (span > int'(trig_cfg.threshold)) begin
            spike_on = 1'b1;
          end else begin
            win_high = '0;
            win_low = s;
          end
          mark_us = now;
        end
      end
    end else begin
      if (!note_on && s > trig_cfg.threshold) begin
        ev.ev_valid = 1'b1;
        ev.ev_value = trig_cfg.out_hi;
        note_on = 1'b1;
      end else if (note_on && s <= trig_cfg.threshold) begin
        ev.ev_valid = 1'b1;
        ev.ev_value = trig_cfg.out_lo;
        note_on = 1'b0;
        holdoff_on = 1'b1;
        mark_us = now;
      end
    end
    ev.ev_note = trig_cfg.note_number;
    ev.touch = pressure;
    return ev;
  endfunction

  function automatic logic [TIME_BITS-1:0] tick(input logic [TIME_BITS-1:0] step_us);
    stamp_us = stamp_us + step_us;
    return stamp_us;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    note_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_events.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_valid !== want.ev_valid) begin
          $error("event_valid: expected %0d, got %0d", want.ev_valid, out_event_valid);
          mismatches++;
        end
        if (out_event_value !== want.ev_value) begin
          $error("event_value: expected %0d, got %0d", want.ev_value, out_event_value);
          mismatches++;
        end
        if (out_event_note !== want.ev_note) begin
          $error("event_note: expected %0d, got %0d", want.ev_note, out_event_note);
          mismatches++;
        end
        if (out_aftertouch !== want.touch) begin
          $error("aftertouch: expected %0d, got %0d", $signed(want.touch), out_aftertouch);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles with no request, result or register access
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("piezo_note_trigger_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample,
                             input logic [TIME_BITS-1:0] now);
    int gap;
    in_valid <= 1'b1;
    in_sample <= sample;
    in_now_us <= now;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_events.push_back(next_note_event(sample, now));
    items_sent++;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = 1;
      while ($urandom_range(99) < sender_idle_pct && gap < 12) gap++;
      if ($urandom_range(39) == 0) gap += $urandom_range(10, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: all results back, then let the datapath run out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] stored;
    case (idx)
      REG_VMODE: begin
        trig_cfg.velocity_mode = value[0];
        stored = 32'(trig_cfg.velocity_mode);
      end
      REG_THRESH: begin
        trig_cfg.threshold = value[SAMPLE_BITS-1:0];
        stored = 32'(trig_cfg.threshold);
      end
      REG_FLOOR: begin
        trig_cfg.floor_level = value[SAMPLE_BITS-1:0];
        stored = 32'(trig_cfg.floor_level);
      end
      REG_HOLDOFF: begin
        trig_cfg.holdoff_us = value;
        stored = trig_cfg.holdoff_us;
      end
      REG_DIVIDER: begin
        trig_cfg.scale_divider = value[SAMPLE_BITS-1:0];
        stored = 32'(trig_cfg.scale_divider);
      end
      REG_OUT_LO: begin
        trig_cfg.out_lo = value[VAL_BITS-1:0];
        stored = 32'(trig_cfg.out_lo);
      end
      REG_OUT_HI: begin
        trig_cfg.out_hi = value[VAL_BITS-1:0];
        stored = 32'(trig_cfg.out_hi);
      end
      default: begin
        trig_cfg.note_number = value[VAL_BITS-1:0];
        stored = 32'(trig_cfg.note_number);
      end
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // read it back
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== stored) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), stored, cfg_prdata);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_plain_threshold();
    settings_used++;
    stamp_us = 32'd1000;
    send_sample(10'd0, stamp_us);
    send_sample(10'd81, tick(10));     // on at out_hi
    send_sample(10'd1023, tick(10));
    send_sample(10'd80, tick(10));     // at threshold counts as off
    send_sample(10'd0, tick(4000));    // holdoff, too early
    send_sample(10'd3, tick(7000));    // holdoff ends at the floor
    send_sample(10'd81, tick(10));
    send_sample(10'd40, tick(10));
    settle();
  endtask

  task automatic test_velocity_strike();
    write_reg(REG_VMODE, 32'd1);
    write_reg(REG_THRESH, 32'd100);
    write_reg(REG_DIVIDER, 32'd4);
    write_reg(REG_OUT_LO, 32'd5);
    write_reg(REG_OUT_HI, 32'd120);
    write_reg(REG_HOLDOFF, 32'd200);
    write_reg(REG_FLOOR, 32'd10);
    write_reg(REG_NOTE, 32'd127);
    settings_used++;
    // timestamps run across the 32-bit wrap
    stamp_us = 32'hFFFF_FF80;
    send_sample(10'd5, stamp_us);
    send_sample(10'd20, tick(150));    // quiet window
    send_sample(10'd600, tick(150));   // spike seen
    send_sample(10'd900, tick(150));   // note on with clamped peak
    send_sample(10'd400, tick(50));    // pressure update
    send_sample(10'd99, tick(50));     // below threshold: off
    send_sample(10'd5, tick(100));
    send_sample(10'd5, tick(201));
    settle();
  endtask

  task automatic test_divider_clamp();
    write_reg(REG_THRESH, 32'd50);
    write_reg(REG_DIVIDER, 32'd0);     // zero acts as one
    write_reg(REG_OUT_LO, 32'd100);    // bounds swapped
    write_reg(REG_OUT_HI, 32'd20);
    write_reg(REG_HOLDOFF, 32'd0);
    write_reg(REG_FLOOR, 32'd1023);
    settings_used++;
    send_sample(10'd0, tick(150));
    send_sample(10'd0, tick(150));
    send_sample(10'd900, tick(150));
    send_sample(10'd900, tick(150));
    send_sample(10'd60, tick(20));
    send_sample(10'd10, tick(20));
    settle();
  endtask

  task automatic test_mode_switch();
    write_reg(REG_VMODE, 32'd0);
    write_reg(REG_THRESH, 32'd200);
    settings_used++;
    send_sample(10'd0, tick(10));
    send_sample(10'd500, tick(10));    // plain note on
    settle();
    // the note carries on under velocity rules
    write_reg(REG_VMODE, 32'd1);
    settings_used++;
    send_sample(10'd700, tick(10));
    send_sample(10'd100, tick(10));
    settle();
  endtask

  task automatic play_strike();
    int thr, flr, peak, steps, k;
    thr = int'(trig_cfg.threshold);
    flr = int'(trig_cfg.floor_level);
    steps = $urandom_range(1, 3);
    repeat (steps) begin
      send_sample(SAMPLE_BITS'($urandom_range(0, flr)), tick($urandom_range(20, 130)));
    end
    peak = $urandom_range(thr, 1023);
    steps = $urandom_range(1, 4);
    for (k = 1; k <= steps; k++) begin
      send_sample(SAMPLE_BITS'(peak * k / steps), tick($urandom_range(30, 140)));
    end
    steps = $urandom_range(0, 5);
    repeat (steps) begin
      send_sample(SAMPLE_BITS'($urandom_range(thr, peak)), tick($urandom_range(5, 150)));
    end
    steps = $urandom_range(1, 2);
    repeat (steps) begin
      send_sample(SAMPLE_BITS'($urandom_range(0, thr > 0 ? thr - 1 : 0)),
                  tick($urandom_range(5, 100)));
    end
    // rest at the floor, usually long enough to clear holdoff
    if (trig_cfg.holdoff_us < 32'd100000 && $urandom_range(99) < 75) begin
      send_sample(SAMPLE_BITS'($urandom_range(0, flr)),
                  tick(trig_cfg.holdoff_us + $urandom_range(1, 150)));
    end else begin
      send_sample(SAMPLE_BITS'($urandom_range(0, flr)), tick($urandom_range(0, 300)));
    end
  endtask

  task automatic play_noise();
    int n, roll;
    n = $urandom_range(4, 12);
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_sample(SAMPLE_BITS'($urandom_range(0, 1023)), tick($urandom()));
      end else if (roll < 30) begin
        send_sample(SAMPLE_BITS'($urandom_range(0, 1023)), tick($urandom_range(0, 5)));
      end else begin
        send_sample(SAMPLE_BITS'($urandom_range(0, 1023)), tick($urandom_range(0, 200)));
      end
    end
  endtask

  task automatic test_random_sessions();
    int phase, goal;
    stamp_us = $urandom();
    for (phase = 0; phase < SESSIONS; phase++) begin
      write_reg(REG_VMODE, (phase % 3 != 0) ? 32'd1 : 32'd0);
      write_reg(REG_THRESH, phase == 2 ? 32'd0 : phase == 5 ? 32'd1023 :
                            32'($urandom_range(30, 300)));
      write_reg(REG_FLOOR, phase == 3 ? 32'd1023 : phase == 6 ? 32'd0 :
                           32'($urandom_range(0, 40)));
      write_reg(REG_HOLDOFF, phase == 4 ? 32'd0 : phase == 7 ? 32'hFFFF_FFFF :
                             phase == 9 ? 32'd10000 : 32'($urandom_range(0, 600)));
      write_reg(REG_DIVIDER, phase == 1 ? 32'd1 : phase == 5 ? 32'd1023 :
                             phase == 8 ? 32'd0 : 32'($urandom_range(2, 16)));
      write_reg(REG_OUT_LO, phase == 3 ? 32'd127 : phase == 6 ? 32'd0 :
                            32'($urandom_range(0, 30)));
      write_reg(REG_OUT_HI, phase == 3 ? 32'd0 : phase == 6 ? 32'd127 :
                            32'($urandom_range(90, 127)));
      write_reg(REG_NOTE, phase == 0 ? 32'd127 : phase == 9 ? 32'd0 :
                          32'($urandom_range(0, 127)));
      settings_used++;
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 60; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 60; end
        default: begin sender_idle_pct = 22; stall_pct = 22; end
      endcase
      goal = items_sent + SESSION_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 80) play_strike();
        else play_noise();
      end
      settle();
    end
  endtask

  initial begin
    trig_cfg.velocity_mode = 1'b0;
    trig_cfg.threshold = THR_RESET;
    trig_cfg.floor_level = FLOOR_RESET;
    trig_cfg.holdoff_us = HOLD_RESET;
    trig_cfg.scale_divider = DIV_RESET;
    trig_cfg.out_lo = '0;
    trig_cfg.out_hi = HI_RESET;
    trig_cfg.note_number = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_threshold();
    test_velocity_strike();
    test_divider_clamp();
    test_mode_switch();
    test_random_sessions();
    $display("Checked %0d note results for %0d sensor samples under %0d register settings,",
             results_seen, items_sent, settings_used);
    $display("plain and velocity modes, with sender gaps and receiver stalls.");
    if (mismatches == 0) begin
      $display("piezo_note_trigger_unit: match");
    end else begin
      $display("piezo_note_trigger_unit: mismatch");
    end
    $finish;
  end

endmodule

### piezo_note_trigger_unit.f
+incdir+rtl
rtl/pnt_pkg.sv
rtl/pnt_cfg_regs.sv
rtl/pnt_ctrl.sv
rtl/pnt_datapath.sv
rtl/piezo_note_trigger_unit.sv
rtl/pnt_checker.sv
verif/piezo_note_trigger_unit_tb.sv
